[rtl/deq_pkg.sv]
// ----------------------------------------------------------------------------
// deq_pkg
// Types, codes and defaults shared by the double-ended queue modules.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int WORD_W    = 32;
  localparam int DEPTH_DEF = 128;

  localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [2:0] ACT_POP_BACK   = 3'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic [2:0]               action;
    logic signed [WORD_W-1:0] value;
  } deq_in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [WORD_W-1:0] popped_value;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] back_value;
    logic [7:0]               entry_count;
    logic                     is_empty;
  } deq_out_t;

  // Cell command: head end of a chain is cell 0, tail end the last cell.
  typedef struct packed {
    logic              push_head;
    logic              push_tail;
    logic              pop_head;
    logic              pop_tail;
    logic [WORD_W-1:0] word;
  } deq_cmd_t;

endpackage

[rtl/deq_cell.sv]
// ----------------------------------------------------------------------------
// deq_cell
// One storage cell: a word and a valid bit, shifted to and from its neighbors.
// ----------------------------------------------------------------------------
module deq_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  deq_pkg::deq_cmd_t               cmd,
  input  logic [deq_pkg::WORD_W-1:0]      prev_data,
  input  logic                            prev_valid,
  input  logic [deq_pkg::WORD_W-1:0]      next_data,
  input  logic                            next_valid,
  output logic [deq_pkg::WORD_W-1:0]      q_data,
  output logic                            q_valid,
  output logic [deq_pkg::WORD_W-1:0]      d_data
);
  import deq_pkg::*;

  logic [WORD_W-1:0] data_r, data_nxt;
  logic              valid_r, valid_nxt;

  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    if (cmd.push_head) begin
      data_nxt  = prev_data;
      valid_nxt = prev_valid;
    end else if (cmd.pop_head) begin
      data_nxt  = next_data;
      valid_nxt = next_valid;
    end else if (cmd.push_tail && prev_valid && !valid_r) begin
      data_nxt  = cmd.word;
      valid_nxt = 1'b1;
    end else if (cmd.pop_tail && valid_r && !next_valid) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q_data  = data_r;
  assign q_valid = valid_r;
  assign d_data  = data_nxt;

endmodule

[rtl/deq_chain.sv]
// ----------------------------------------------------------------------------
// deq_chain
// Row of cells kept packed against cell 0; the head word sits in cell 0.
// ----------------------------------------------------------------------------
module deq_chain #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  deq_pkg::deq_cmd_t               cmd,
  output logic [deq_pkg::WORD_W-1:0]      head_data,
  output logic [deq_pkg::WORD_W-1:0]      head_data_nxt,
  output logic                            head_valid
);
  import deq_pkg::*;

  logic [WORD_W-1:0] q_data  [DEPTH];
  logic              q_valid [DEPTH];
  logic [WORD_W-1:0] d_data  [DEPTH];
  logic [WORD_W-1:0] prev_data [DEPTH];
  logic              prev_valid [DEPTH];
  logic [WORD_W-1:0] next_data [DEPTH];
  logic              next_valid [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign prev_data[i]  = cmd.word;
      assign prev_valid[i] = 1'b1;
    end else begin : g_mid_prev
      assign prev_data[i]  = q_data[i-1];
      assign prev_valid[i] = q_valid[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_data[i]  = '0;
      assign next_valid[i] = 1'b0;
    end else begin : g_mid_next
      assign next_data[i]  = q_data[i+1];
      assign next_valid[i] = q_valid[i+1];
    end

    deq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .prev_data  (prev_data[i]),
      .prev_valid (prev_valid[i]),
      .next_data  (next_data[i]),
      .next_valid (next_valid[i]),
      .q_data     (q_data[i]),
      .q_valid    (q_valid[i]),
      .d_data     (d_data[i])
    );
  end

  assign head_data     = q_data[0];
  assign head_data_nxt = d_data[0];
  assign head_valid    = q_valid[0];

endmodule

[rtl/double_ended_queue.sv]
// ----------------------------------------------------------------------------
// double_ended_queue
// Double-ended queue of signed 32-bit words with one status word per request.
// ----------------------------------------------------------------------------
// Takes one request per clock while in_stall is low and returns its result
// word on the cycle after acceptance through a single output register;
// in_stall rises only while that register holds a word the receiver is
// stalling. Storage is two mirrored rows of DEPTH cells, one packed toward
// the front and one toward the back, so both end words sit in fixed cells
// and every cell moves only to its neighbors. No initialization pass is
// needed after reset; the queue is usable in the first cycle out of reset.
module double_ended_queue #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  deq_pkg::deq_in_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output deq_pkg::deq_out_t  out_data
);
  import deq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]     count_r, count_nxt;
  logic              out_valid_r;
  deq_out_t          out_data_r, res;
  logic              in_acc, is_push, is_pop, full, empty, go;
  logic [1:0]        status;
  deq_cmd_t          cmd_a, cmd_b;
  logic [WORD_W-1:0] a_head, a_head_nxt, b_head, b_head_nxt;
  logic              a_head_valid, b_head_valid;

  assign in_acc  = in_valid && !in_stall;
  assign in_stall = out_valid_r && out_stall;
  assign is_push = (in_data.action == ACT_PUSH_FRONT) || (in_data.action == ACT_PUSH_BACK);
  assign is_pop  = (in_data.action == ACT_POP_FRONT) || (in_data.action == ACT_POP_BACK);
  assign full    = count_r == CW'(DEPTH);
  assign empty   = count_r == '0;

  always_comb begin
    status = ST_OK;
    if (is_push && full) begin
      status = ST_OVERFLOW;
    end else if (is_pop && empty) begin
      status = ST_UNDERFLOW;
    end
  end

  assign go = in_acc && (status == ST_OK);

  // front row: head is the front word; back row: head is the back word
  assign cmd_a.push_head = go && (in_data.action == ACT_PUSH_FRONT);
  assign cmd_a.push_tail = go && (in_data.action == ACT_PUSH_BACK);
  assign cmd_a.pop_head  = go && (in_data.action == ACT_POP_FRONT);
  assign cmd_a.pop_tail  = go && (in_data.action == ACT_POP_BACK);
  assign cmd_a.word      = in_data.value;

  assign cmd_b.push_head = cmd_a.push_tail;
  assign cmd_b.push_tail = cmd_a.push_head;
  assign cmd_b.pop_head  = cmd_a.pop_tail;
  assign cmd_b.pop_tail  = cmd_a.pop_head;
  assign cmd_b.word      = in_data.value;

  deq_chain #(.DEPTH(DEPTH)) u_front_row (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd_a),
    .head_data     (a_head),
    .head_data_nxt (a_head_nxt),
    .head_valid    (a_head_valid)
  );

  deq_chain #(.DEPTH(DEPTH)) u_back_row (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd_b),
    .head_data     (b_head),
    .head_data_nxt (b_head_nxt),
    .head_valid    (b_head_valid)
  );

  always_comb begin
    count_nxt = count_r;
    if (go && is_push) begin
      count_nxt = count_r + CW'(1);
    end else if (go && is_pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_comb begin
    res.status       = status;
    res.popped_value = '0;
    if (go && (in_data.action == ACT_POP_FRONT)) begin
      res.popped_value = a_head;
    end else if (go && (in_data.action == ACT_POP_BACK)) begin
      res.popped_value = b_head;
    end
    res.is_empty    = count_nxt == '0;
    res.front_value = res.is_empty ? '0 : a_head_nxt;
    res.back_value  = res.is_empty ? '0 : b_head_nxt;
    res.entry_count = 8'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("count above depth");

  a_front_row_occupied: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) == a_head_valid)
    else $error("front row head valid disagrees with count");

  a_back_row_occupied: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) == b_head_valid)
    else $error("back row head valid disagrees with count");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (count_r == $past(count_r)) || (count_r == $past(count_r) + CW'(1))
               || (count_r == $past(count_r) - CW'(1)))
    else $error("count moved by more than one word");

  a_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_pop && empty) |=> out_valid_r && (out_data_r.status == ST_UNDERFLOW))
    else $error("pop of empty queue not flagged");

endmodule

[tb/sv/double_ended_queue_tb.sv]
// ----------------------------------------------------------------------------
// double_ended_queue_tb
// Self-checking bench for the double-ended queue: a short scripted sequence
// at the edges of the queue, then phases of random pushes and pops that fill
// the ring to overflow and drain it to underflow. Every result word is
// compared field by field against a scripted result or ring-buffer predictor.
// ----------------------------------------------------------------------------
module double_ended_queue_tb;
  import deq_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam int IDX_W = $clog2(DEPTH);

  localparam logic [2:0] ACT_QUERY   = 3'd4;
  localparam logic [2:0] ACT_SPARE_A = 3'd5;
  localparam logic [2:0] ACT_SPARE_B = 3'd6;
  localparam logic [2:0] ACT_SPARE_C = 3'd7;

  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;

  localparam int RANDOM_WORDS = 800;
  localparam int PHASE_LEN    = 200;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 64;

  typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN} mix_t;

  typedef struct {
    deq_in_t  word;
    bit       typed;
    deq_out_t result;
  } script_row_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  deq_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  deq_out_t out_data;

  double_ended_queue i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic signed [WORD_W-1:0] ring [DEPTH];
  int unsigned ring_head = 0;
  int unsigned ring_fill = 0;

  deq_out_t    expected_words[$];
  script_row_t script[$];
  int          errors = 0;
  int          words_checked = 0;
  bit          steady = 1'b0;

  function automatic logic [IDX_W-1:0] ring_pos(input int unsigned base,
                                                input int unsigned off);
    return IDX_W'((base + off) % DEPTH);
  endfunction

  function automatic deq_out_t apply_action(input deq_in_t w);
    deq_out_t r;
    r = '0;
    r.status = ST_OK;
    case (w.action)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (ring_fill == DEPTH) begin
          r.status = ST_OVERFLOW;
        end else if (w.action == ACT_PUSH_FRONT) begin
          ring_head = (ring_head + DEPTH - 1) % DEPTH;
          ring[ring_pos(ring_head, 0)] = w.value;
          ring_fill++;
        end else begin
          ring[ring_pos(ring_head, ring_fill)] = w.value;
          ring_fill++;
        end
      end
      ACT_POP_FRONT, ACT_POP_BACK: begin
        if (ring_fill == 0) begin
          r.status = ST_UNDERFLOW;
        end else if (w.action == ACT_POP_FRONT) begin
          r.popped_value = ring[ring_pos(ring_head, 0)];
          ring_head = (ring_head + 1) % DEPTH;
          ring_fill--;
        end else begin
          r.popped_value = ring[ring_pos(ring_head, ring_fill - 1)];
          ring_fill--;
        end
      end
      default: ;
    endcase
    if (ring_fill != 0) begin
      r.front_value = ring[ring_pos(ring_head, 0)];
      r.back_value  = ring[ring_pos(ring_head, ring_fill - 1)];
    end
    r.entry_count = 8'(ring_fill);
    r.is_empty    = (ring_fill == 0);
    return r;
  endfunction

  function automatic deq_out_t mk_result(input logic [1:0] st,
                                         input logic signed [WORD_W-1:0] popped,
                                         input logic signed [WORD_W-1:0] front,
                                         input logic signed [WORD_W-1:0] back,
                                         input logic [7:0] cnt,
                                         input logic empty);
    deq_out_t r;
    r.status       = st;
    r.popped_value = popped;
    r.front_value  = front;
    r.back_value   = back;
    r.entry_count  = cnt;
    r.is_empty     = empty;
    return r;
  endfunction

  function automatic void add_row(input logic [2:0] act,
                                  input logic signed [WORD_W-1:0] val,
                                  input bit typed,
                                  input deq_out_t res);
    script_row_t row;
    row.word.action = act;
    row.word.value  = val;
    row.typed       = typed;
    row.result      = res;
    script.insert(script.size(), row);
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 19);
    if (steady || roll < 12) return 0;
    if (roll < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [WORD_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return '0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_action(input mix_t mode);
    int  roll;
    bit  push;
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      case ($urandom_range(0, 3))
        0: return ACT_QUERY;
        1: return ACT_SPARE_A;
        2: return ACT_SPARE_B;
        default: return ACT_SPARE_C;
      endcase
    end
    case (mode)
      MIX_FILL:  push = (roll < 92);
      MIX_DRAIN: push = (roll >= 92);
      default:   push = (roll < 52);
    endcase
    if (push) return $urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
    return $urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT;
  endfunction

  task automatic offer(input deq_in_t w, input bit typed, input deq_out_t res);
    int       gap;
    deq_out_t predicted;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    predicted = apply_action(w);
    expected_words.insert(expected_words.size(), typed ? res : predicted);
  endtask

  function automatic void field_check(input string tag, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, tag, want, got);
      errors++;
    end
  endfunction

  task automatic check_word(input deq_out_t got);
    deq_out_t want;
    if (expected_words.size() == 0) begin
      $display("%0t: result word with nothing expected, actual %h", $time, got);
      errors++;
      return;
    end
    want = expected_words[0];
    expected_words.delete(0);
    field_check("status", 32'(want.status), 32'(got.status));
    field_check("popped_value", want.popped_value, got.popped_value);
    field_check("front_value", want.front_value, got.front_value);
    field_check("back_value", want.back_value, got.back_value);
    field_check("entry_count", 32'(want.entry_count), 32'(got.entry_count));
    field_check("is_empty", 32'(want.is_empty), 32'(got.is_empty));
    words_checked++;
  endtask

  // result side: random stalls plus one long hold to back the queue up
  initial begin
    int hold;
    bit pressed;
    hold    = 0;
    pressed = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!pressed && words_checked >= HOLD_AT) begin
        pressed = 1'b1;
        hold    = HOLD_CYCLES;
      end else if (hold == 0 && $urandom_range(0, 3) == 0) begin
        hold = pick_gap();
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
      end
      @(posedge clk);
      if (out_valid && !out_stall) check_word(out_data);
    end
  end

  initial begin
    deq_in_t  w;
    deq_out_t none;
    mix_t     mode;
    none = '0;

    add_row(ACT_QUERY,      '0,       1, mk_result(ST_OK, 0, 0, 0, 8'd0, 1'b1));
    add_row(ACT_POP_FRONT,  -1,       1, mk_result(ST_UNDERFLOW, 0, 0, 0, 8'd0, 1'b1));
    add_row(ACT_POP_BACK,   WORD_MAX, 1, mk_result(ST_UNDERFLOW, 0, 0, 0, 8'd0, 1'b1));
    add_row(ACT_PUSH_FRONT, WORD_MIN, 1,
            mk_result(ST_OK, 0, WORD_MIN, WORD_MIN, 8'd1, 1'b0));
    add_row(ACT_PUSH_BACK,  WORD_MAX, 1,
            mk_result(ST_OK, 0, WORD_MIN, WORD_MAX, 8'd2, 1'b0));
    add_row(ACT_SPARE_A,    -1,       1,
            mk_result(ST_OK, 0, WORD_MIN, WORD_MAX, 8'd2, 1'b0));
    add_row(ACT_SPARE_B,    WORD_MIN, 0, none);
    add_row(ACT_SPARE_C,    WORD_MAX, 0, none);
    add_row(ACT_POP_BACK,   '0,       1,
            mk_result(ST_OK, WORD_MAX, WORD_MIN, WORD_MIN, 8'd1, 1'b0));
    add_row(ACT_POP_FRONT,  '0,       1, mk_result(ST_OK, WORD_MIN, 0, 0, 8'd0, 1'b1));
    add_row(ACT_PUSH_BACK,  '0,       0, none);
    add_row(ACT_PUSH_FRONT, -1,       0, none);
    add_row(ACT_PUSH_BACK,  32'sh5555_5555, 0, none);
    add_row(ACT_PUSH_FRONT, 32'shaaaa_aaaa, 0, none);
    add_row(ACT_QUERY,      '0,       0, none);
    add_row(ACT_POP_FRONT,  '0,       0, none);
    add_row(ACT_POP_BACK,   '0,       0, none);
    add_row(ACT_POP_BACK,   '0,       0, none);
    add_row(ACT_POP_FRONT,  '0,       0, none);
    add_row(ACT_POP_BACK,   '0,       1, mk_result(ST_UNDERFLOW, 0, 0, 0, 8'd0, 1'b1));
    add_row(ACT_PUSH_FRONT, 1,        1, mk_result(ST_OK, 0, 1, 1, 8'd1, 1'b0));
    add_row(ACT_POP_FRONT,  '0,       1, mk_result(ST_OK, 1, 0, 0, 8'd0, 1'b1));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) offer(script[i].word, script[i].typed, script[i].result);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      case ((n / PHASE_LEN) % 4)
        0: mode = MIX_FILL;
        2: mode = MIX_DRAIN;
        default: mode = MIX_BALANCED;
      endcase
      steady   = ((n / PHASE_LEN) == 3) && (n % PHASE_LEN < PHASE_LEN / 2);
      w.action = pick_action(mode);
      w.value  = pick_value();
      offer(w, 0, none);
    end
    steady = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
